@@ design/wildcard_byte_pattern_scanner_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Wildcard byte pattern scanner: assertion macros
// Shared concurrent assertion forms. They sample on clk and are disabled
// while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WBPS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/wbps_pkg.sv @@
// ---------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Register map, fixed field widths and the status type shared by the modules.
// ---------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LENGTH = 3'd0,
		REG_PATTERN_LO     = 3'd1,
		REG_PATTERN_MID    = 3'd2,
		REG_PATTERN_UPPER  = 3'd3,
		REG_PATTERN_TOP    = 3'd4,
		REG_WILDCARD_MASK  = 3'd5,
		REG_ALIGN_BYTES    = 3'd6
	} cfg_reg_t;

	// Field widths
	localparam int BYTE_W             = 8;
	localparam int PATTERN_LENGTH_W   = 6;
	localparam int PATTERN_REGS       = 4;
	localparam int BYTES_PER_REG      = CFG_DATA_W / BYTE_W;
	localparam int REG_PATTERN_BYTES  = PATTERN_REGS * BYTES_PER_REG;
	localparam int WILDCARD_W         = 32;
	localparam int ALIGN_W            = 8;

	// One aligned compare entry: care bit on top of the pattern byte.
	localparam int ENTRY_W = BYTE_W + 1;

	// Status of the window stage as seen by the output side.
	typedef struct packed {
		logic valid;
		logic hit;
	} wbps_s1_stat_t;

endpackage

`default_nettype wire

@@ design/wbps_ifs.sv @@
// ---------------------------------------------------------------------------
// Wildcard byte pattern scanner channel interfaces
// Valid/ready channels for the byte stream, the match results and the
// configuration writes.
// ---------------------------------------------------------------------------
`default_nettype none

// Scanned memory bytes.
interface wbps_scan_if #(
	parameter int ADDR_BITS = 48
);
	logic                 valid;
	logic                 ready;
	logic [7:0]           mem_byte;
	logic [ADDR_BITS-1:0] byte_addr;
	logic                 region_first;

	modport source (output valid, mem_byte, byte_addr, region_first, input ready);
	modport sink   (input valid, mem_byte, byte_addr, region_first, output ready);
endinterface

// Match start addresses.
interface wbps_found_if #(
	parameter int ADDR_BITS = 48
);
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] hit_addr;

	modport source (output valid, hit_addr, input ready);
	modport sink   (input valid, hit_addr, output ready);
endinterface

// Register writes.
interface wbps_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [wbps_pkg::CFG_IDX_W-1:0]   index;
	logic [wbps_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/wildcard_byte_pattern_scanner_unit.sv @@
// ---------------------------------------------------------------------------
// Wildcard byte pattern scanner unit
// Scans a byte stream for a pattern of up to MAX_PATTERN bytes with per-byte
// wildcards and reports the aligned start address of every match.
// ---------------------------------------------------------------------------
`default_nettype none

// The unit accepts one memory byte per clock on the stream channel while it is
// not stalled; the single pass compare of the whole window sets this rate. The
// match start address is presented on the found channel by the output register,
// loaded from the window stage that holds the byte which completes the match
// once that register is free. A byte is compared in a single pass:
// it is shifted into a registered window, the whole window is compared in
// parallel against the pattern in the following cycle, and a hit is loaded into
// the output register. A waiting result stalls the stream only when the byte in
// the window stage also hits. Configuration writes are always accepted and
// take effect for bytes transferred from the next cycle on; write only while no
// byte is in flight. The window fill count restarts at a byte with region_first set.
module wildcard_byte_pattern_scanner_unit #(
	parameter int MAX_PATTERN = 32,
	parameter int ADDR_BITS   = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	wbps_scan_if.sink    stream,
	wbps_found_if.source found,
	wbps_cfg_if.sink     cfg
);
	import wbps_pkg::*;

	`include "wildcard_byte_pattern_scanner_unit_macros.svh"

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int ALN_W = MAX_PATTERN * ENTRY_W;

	logic [LEN_W-1:0]     len;
	logic [ALIGN_W-1:0]   align_mask;
	logic [ALN_W-1:0]     aligned;
	wbps_s1_stat_t        stat;
	logic [ADDR_BITS-1:0] start_addr;

	logic                 take;
	logic                 s1_free;
	logic                 out_free;
	logic                 found_valid_q;
	logic [ADDR_BITS-1:0] hit_addr_q;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	wbps_cfg #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg.valid),
		.wr_index   (cfg.index),
		.wr_data    (cfg.data),
		.len        (len),
		.align_mask (align_mask),
		.aligned    (aligned)
	);

	// Flow control: the window stage moves on unless its hit cannot be stored.
	assign out_free     = !found_valid_q || found.ready;
	assign s1_free      = !stat.valid || !stat.hit || out_free;
	assign stream.ready = s1_free;
	assign take         = stream.valid && s1_free;

	wbps_core #(
		.MAX_PATTERN (MAX_PATTERN),
		.ADDR_BITS   (ADDR_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.s1_free      (s1_free),
		.mem_byte     (stream.mem_byte),
		.byte_addr    (stream.byte_addr),
		.region_first (stream.region_first),
		.len          (len),
		.align_mask   (align_mask),
		.aligned      (aligned),
		.stat         (stat),
		.start_addr   (start_addr)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_valid_q <= 1'b0;
		end else if (out_free) begin
			found_valid_q <= stat.valid && stat.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && stat.valid && stat.hit) begin
			hit_addr_q <= start_addr;
		end
	end

	assign found.valid    = found_valid_q;
	assign found.hit_addr = hit_addr_q;

	// A hit that finds the output free is reported at the next edge.
	`WBPS_ASSERT_NEXT(a_hit_reported, stat.valid && stat.hit && out_free, found_valid_q && (hit_addr_q == $past(start_addr)), "window hit was not loaded into the output register")
	// The first byte of a region cannot complete a pattern longer than one byte.
	`WBPS_ASSERT_NEXT(a_region_restart, take && stream.region_first && (len > LEN_W'(1)), !stat.hit, "match reported across a region start")
	// Every reported start meets the alignment.
	`WBPS_ASSERT_SAME(a_start_aligned, found_valid_q, (hit_addr_q[ALIGN_W-1:0] & align_mask) == '0, "reported start address is not aligned")

endmodule

`default_nettype wire

@@ design/wbps_cfg.sv @@
// ---------------------------------------------------------------------------
// Wildcard byte pattern scanner configuration
// Holds the registers and derives from them registered values of the effective
// pattern length, the alignment mask and the pattern laid out per window slot.
// ---------------------------------------------------------------------------
`default_nettype none

module wbps_cfg #(
	parameter int MAX_PATTERN = 32,
	localparam int LEN_W = $clog2(MAX_PATTERN + 1),
	localparam int ALN_W = MAX_PATTERN * (wbps_pkg::BYTE_W + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [wbps_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [wbps_pkg::CFG_DATA_W-1:0]   wr_data,
	output logic      [LEN_W-1:0]                  len,
	output logic      [wbps_pkg::ALIGN_W-1:0]      align_mask,
	output logic      [ALN_W-1:0]                  aligned
);
	import wbps_pkg::*;

	logic [PATTERN_LENGTH_W-1:0]                 pattern_length_q;
	logic [PATTERN_REGS-1:0][CFG_DATA_W-1:0]     pattern_q;
	logic [WILDCARD_W-1:0]                       wildcard_q;
	logic [ALIGN_W-1:0]                          align_bytes_q;

	logic [LEN_W-1:0]   len_d;
	logic [LEN_W-1:0]   shift_amt;
	logic [ALN_W-1:0]   rev_flat;
	logic [ALN_W-1:0]   aligned_d;
	logic [ALIGN_W-1:0] align_mask_d;
	logic [LEN_W-1:0]   len_q;
	logic [ALIGN_W-1:0] align_mask_q;
	logic [ALN_W-1:0]   aligned_q;

	// Register writes; an index past the map is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= PATTERN_LENGTH_W'(1);
			pattern_q        <= '0;
			wildcard_q       <= '0;
			align_bytes_q    <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_PATTERN_LENGTH: pattern_length_q <= wr_data[PATTERN_LENGTH_W-1:0];
				REG_PATTERN_LO:     pattern_q[0]     <= wr_data;
				REG_PATTERN_MID:    pattern_q[1]     <= wr_data;
				REG_PATTERN_UPPER:  pattern_q[2]     <= wr_data;
				REG_PATTERN_TOP:    pattern_q[3]     <= wr_data;
				REG_WILDCARD_MASK:  wildcard_q       <= wr_data[WILDCARD_W-1:0];
				REG_ALIGN_BYTES:    align_bytes_q    <= wr_data[ALIGN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective length: zero acts as one, and long patterns clip to the window.
	always_comb begin
		priority if (pattern_length_q == '0) begin
			len_d = LEN_W'(1);
		end else if (int'(pattern_length_q) > MAX_PATTERN) begin
			len_d = LEN_W'(MAX_PATTERN);
		end else begin
			len_d = LEN_W'(pattern_length_q);
		end
	end

	// Pattern entries in reverse order; bytes past the registers are zero and must match.
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_entry
		if (k < REG_PATTERN_BYTES) begin : g_reg
			assign rev_flat[(MAX_PATTERN-1-k)*ENTRY_W +: ENTRY_W] =
				{~wildcard_q[k], pattern_q[k / BYTES_PER_REG][(k % BYTES_PER_REG)*BYTE_W +: BYTE_W]};
		end else begin : g_pad
			assign rev_flat[(MAX_PATTERN-1-k)*ENTRY_W +: ENTRY_W] = {1'b1, {BYTE_W{1'b0}}};
		end
	end

	// Slot j of the window meets pattern byte len-1-j. Slots at or past len get care 0.
	assign shift_amt    = LEN_W'(MAX_PATTERN) - len_d;
	assign aligned_d    = rev_flat >> (shift_amt * ENTRY_W);
	assign align_mask_d = (align_bytes_q != '0) ? (align_bytes_q - ALIGN_W'(1)) : '0;

	// Derived values are refreshed every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= LEN_W'(1);
			align_mask_q <= '0;
		end else begin
			len_q        <= len_d;
			align_mask_q <= align_mask_d;
		end
	end

	always_ff @(posedge clk) begin
		aligned_q <= aligned_d;
	end

	assign len        = len_q;
	assign align_mask = align_mask_q;
	assign aligned    = aligned_q;

endmodule

`default_nettype wire

@@ design/wbps_core.sv @@
// ---------------------------------------------------------------------------
// Wildcard byte pattern scanner window stage
// Shift-register window with fill count, the address of the newest byte, and
// the parallel compare that decides a hit and its start address.
// ---------------------------------------------------------------------------
`default_nettype none

module wbps_core #(
	parameter int MAX_PATTERN = 32,
	parameter int ADDR_BITS   = 48,
	localparam int LEN_W = $clog2(MAX_PATTERN + 1),
	localparam int ALN_W = MAX_PATTERN * (wbps_pkg::BYTE_W + 1)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           take,
	input  wire logic                           s1_free,
	input  wire logic [wbps_pkg::BYTE_W-1:0]    mem_byte,
	input  wire logic [ADDR_BITS-1:0]           byte_addr,
	input  wire logic                           region_first,
	input  wire logic [LEN_W-1:0]               len,
	input  wire logic [wbps_pkg::ALIGN_W-1:0]   align_mask,
	input  wire logic [ALN_W-1:0]               aligned,
	output wbps_pkg::wbps_s1_stat_t             stat,
	output logic      [ADDR_BITS-1:0]           start_addr
);
	import wbps_pkg::*;

	logic [BYTE_W-1:0]    win_s1 [MAX_PATTERN];
	logic [LEN_W-1:0]     fill_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic                 valid_s1;

	logic [LEN_W-1:0]       fill_base;
	logic [MAX_PATTERN-1:0] mism;
	logic [ADDR_BITS-1:0]   start;
	logic                   aligned_ok;

	// Window shift: slot 0 takes the newest byte.
	always_ff @(posedge clk) begin
		if (take) begin
			for (int j = MAX_PATTERN - 1; j > 0; j--) begin
				win_s1[j] <= win_s1[j-1];
			end
			win_s1[0] <= mem_byte;
			addr_s1   <= byte_addr;
		end
	end

	// Fill count restarts at a region start and saturates at the window depth.
	assign fill_base = region_first ? '0 : fill_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_s1  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (take && (int'(fill_base) < MAX_PATTERN)) begin
				fill_s1 <= fill_base + LEN_W'(1);
			end else if (take) begin
				fill_s1 <= fill_base;
			end
			if (s1_free) begin
				valid_s1 <= take;
			end
		end
	end

	// Per-slot compare against the aligned pattern.
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			mism[j] = aligned[j*ENTRY_W + BYTE_W] &&
				(win_s1[j] != aligned[j*ENTRY_W +: BYTE_W]);
		end
	end

	// Start address wraps; alignment checks only the low bits.
	assign start      = addr_s1 - ADDR_BITS'(len - LEN_W'(1));
	assign aligned_ok = (start[ALIGN_W-1:0] & align_mask) == '0;

	assign stat.valid = valid_s1;
	assign stat.hit   = (fill_s1 >= len) && (mism == '0) && aligned_ok;
	assign start_addr = start;

endmodule

`default_nettype wire
